### rtl/core/i2cbc_pkg.sv
// Package with the types and constants of the I2C bus-clear sequencer.
package i2cbc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SETTLE_TICKS      = 2'd0;
  localparam logic [1:0] CFG_HALF_PERIOD_TICKS = 2'd1;

  // Register values after reset.
  localparam logic [15:0] SETTLE_TICKS_RST      = 16'd10;
  localparam logic [15:0] HALF_PERIOD_TICKS_RST = 16'd20;

  // Sequencer phases, one-hot.
  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_SETTLE   = 8'b0000_0010,
    PH_CLK_LOW  = 8'b0000_0100,
    PH_CLK_HIGH = 8'b0000_1000,
    PH_STOP_PRE = 8'b0001_0000,
    PH_STOP_LOW = 8'b0010_0000,
    PH_STOP_END = 8'b0100_0000,
    PH_DONE     = 8'b1000_0000
  } phase_t;

endpackage

### rtl/core/i2c_bus_clear_sequencer.sv
// Top level of the I2C bus-clear sequencer with its tick-driven control.
//
// Each transfer on the input channel is one timing tick. It carries the start
// request and the SDA level sampled in that tick. For every input transfer the
// block returns exactly one result transfer: the SCL and SDA levels it drives
// in that tick, whether it owns the pins, busy and done flags, the stuck flag
// and the number of recovery clocks sent so far.
// The result of a tick sits in the output register in the cycle after the
// input transfer. Throughput is one tick per cycle unless the output stalls;
// it is set by the single phase/tick-counter update between input and output
// register. in_ready is high whenever the output register is empty or is
// being taken in the same cycle, so a stalled receiver holds the result and
// stops new ticks only while its result is still waiting.
// Configuration writes (settle and half-period tick counts) are always taken,
// with cfg_ready tied high; an index beyond the two registers is ignored.
// A synchronous active-low reset returns the sequencer to idle, clears the
// counters and flags, empties the output register and loads the register
// defaults of 10 and 20 ticks.
module i2c_bus_clear_sequencer
  import i2cbc_pkg::*;
#(
  parameter int unsigned MAX_CLOCKS = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Input tick channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_start_req,
  input  logic        in_sda_sense,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_pins_owned,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_sda_was_stuck,
  output logic [3:0]  out_clocks_sent
);

  localparam logic [3:0] MaxClocks = 4'(MAX_CLOCKS);

  logic [15:0] settle_ticks_r;
  logic [15:0] half_period_ticks_r;

  phase_t      phase_r, phase_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [3:0]  clock_count_r, clock_count_nxt;
  logic        stuck_flag_r, stuck_flag_nxt;

  logic        out_valid_r;
  logic        scl_r, sda_r, own_r, busy_r, done_r;
  logic        scl_nxt, sda_nxt, own_nxt, busy_nxt, done_nxt;

  logic [15:0] step_len;
  logic        step_end;
  logic        in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r      <= SETTLE_TICKS_RST;
      half_period_ticks_r <= HALF_PERIOD_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SETTLE_TICKS:      settle_ticks_r      <= cfg_data;
        CFG_HALF_PERIOD_TICKS: half_period_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The current step lasts half a period in the clock phases, else a settle time.
  assign step_len = (phase_r == PH_CLK_LOW || phase_r == PH_CLK_HIGH) ?
                    half_period_ticks_r : settle_ticks_r;
  // A length of zero ends the step after one tick, as a length of one does.
  assign step_end = ({1'b0, tick_count_r} + 17'd1) >= {1'b0, step_len};

  // Next phase, counters and the levels driven in this tick.
  always_comb begin
    phase_nxt       = phase_r;
    tick_count_nxt  = step_end ? 16'd0 : tick_count_r + 16'd1;
    clock_count_nxt = clock_count_r;
    stuck_flag_nxt  = stuck_flag_r;
    scl_nxt         = 1'b1;
    sda_nxt         = 1'b1;
    own_nxt         = 1'b1;
    busy_nxt        = 1'b1;
    done_nxt        = 1'b0;
    case (phase_r)
      PH_SETTLE: begin
        if (step_end) begin
          stuck_flag_nxt = !in_sda_sense;
          phase_nxt      = in_sda_sense ? PH_STOP_PRE : PH_CLK_LOW;
        end
      end
      PH_CLK_LOW: begin
        scl_nxt = 1'b0;
        if (step_end) phase_nxt = PH_CLK_HIGH;
      end
      PH_CLK_HIGH: begin
        if (step_end) begin
          clock_count_nxt = clock_count_r + 4'd1;
          if (in_sda_sense || clock_count_nxt >= MaxClocks) phase_nxt = PH_STOP_PRE;
          else phase_nxt = PH_CLK_LOW;
        end
      end
      PH_STOP_PRE: begin
        if (step_end) phase_nxt = PH_STOP_LOW;
      end
      PH_STOP_LOW: begin
        sda_nxt = 1'b0;
        if (step_end) phase_nxt = PH_STOP_END;
      end
      PH_STOP_END: begin
        if (step_end) phase_nxt = PH_DONE;
      end
      default: begin
        // Idle or done: the pins go back to the bus controller.
        own_nxt        = 1'b0;
        busy_nxt       = 1'b0;
        done_nxt       = (phase_r == PH_DONE);
        phase_nxt      = PH_IDLE;
        tick_count_nxt = 16'd0;
        if (in_start_req) begin
          phase_nxt       = PH_SETTLE;
          clock_count_nxt = 4'd0;
          stuck_flag_nxt  = 1'b0;
        end
      end
    endcase
  end

  // Sequencer state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_count_r  <= 16'd0;
      clock_count_r <= 4'd0;
      stuck_flag_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      tick_count_r  <= tick_count_nxt;
      clock_count_r <= clock_count_nxt;
      stuck_flag_r  <= stuck_flag_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // Output register payload, loaded with each accepted tick's result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      scl_r  <= scl_nxt;
      sda_r  <= sda_nxt;
      own_r  <= own_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_scl_out       = scl_r;
  assign out_sda_out       = sda_r;
  assign out_pins_owned    = own_r;
  assign out_busy_res      = busy_r;
  assign out_done_res      = done_r;
  assign out_sda_was_stuck = stuck_flag_r;
  assign out_clocks_sent   = clock_count_r;

  // A done tick hands the pins back and is never busy.
  a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_pins_owned && !out_busy_res)
    else $error("done tick while pins still owned");

  // Pins not owned means both lines read released.
  a_released_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pins_owned |-> out_scl_out && out_sda_out)
    else $error("line driven low while pins not owned");

  // Recovery clocks never exceed the limit.
  a_clock_limit: assert property (@(posedge clk) disable iff (!rst_n)
    clock_count_r <= MaxClocks)
    else $error("clock count beyond limit");

  // A stalled result blocks new ticks until it is taken.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(phase_r))
    else $error("sequencer advanced while result stalled");

endmodule
